/* rtl/core/plc_pkg.sv */
`default_nettype none

package plc_pkg;

  // default for the sensor silence limit in ticks
  localparam int SENSOR_TIMEOUT_TICKS_DEF = 30;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int LEVEL_W = 8;
  localparam int DUR_W   = 16;
  localparam int LEFT_W  = 22;
  localparam int RUN_W   = 13;
  localparam int CNT_W   = 32;
  localparam int EVT_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // control constants
  localparam logic [LEVEL_W-1:0] DEF_ON_TH       = 8'd20;
  localparam logic [LEVEL_W-1:0] DEF_OFF_TH      = 8'd80;
  localparam logic [RUN_W-1:0]   DEF_TIMEOUT_SEC = 13'd3600;
  localparam logic [RUN_W-1:0]   MAX_TIMEOUT_SEC = 13'd7200;
  localparam logic [DUR_W-1:0]   MAX_TIMEOUT_MIN = 16'd120;
  localparam logic [RUN_W-1:0]   RUN_SAT         = 13'd8191;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd3;

  // event codes
  localparam logic [EVT_W-1:0] EVT_NONE       = 3'd0;
  localparam logic [EVT_W-1:0] EVT_ON_LOW     = 3'd1;
  localparam logic [EVT_W-1:0] EVT_OFF_HIGH   = 3'd2;
  localparam logic [EVT_W-1:0] EVT_OFF_TIMEOUT = 3'd3;
  localparam logic [EVT_W-1:0] EVT_OFF_SENSOR = 3'd4;
  localparam logic [EVT_W-1:0] EVT_MAN_EXPIRE = 3'd5;
  localparam logic [EVT_W-1:0] EVT_MAN_START  = 3'd6;
  localparam logic [EVT_W-1:0] EVT_MAN_STOP   = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] on_threshold;
    logic [LEVEL_W-1:0] off_threshold;
    logic [DUR_W-1:0]   timeout_minutes;
  } plc_cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [LEVEL_W-1:0] level_pct;
    logic [DUR_W-1:0]   duration_min;
  } plc_item_t;

  // controller state except the sensor silence counter
  typedef struct packed {
    logic               running;
    logic               override_on;
    logic [LEFT_W-1:0]  override_left;
    logic [RUN_W-1:0]   run_seconds;
    logic               sensor_seen;
    logic [LEVEL_W-1:0] last_level;
    logic [CNT_W-1:0]   total_run;
    logic [CNT_W-1:0]   ticks_up;
  } plc_state_t;

  typedef struct packed {
    logic               pump_on;
    logic               sensor_present;
    logic               manual_active;
    logic [LEFT_W-1:0]  override_secs_left;
    logic [CNT_W-1:0]   pump_runtime_total;
    logic [CNT_W-1:0]   uptime_sec;
    logic [LEVEL_W-1:0] level_now;
    logic [EVT_W-1:0]   event_res;
  } plc_result_t;

endpackage

`default_nettype wire

/* rtl/core/plc_ctrl.sv */
`default_nettype none

module plc_ctrl #(
  parameter int SENSOR_TIMEOUT_TICKS = plc_pkg::SENSOR_TIMEOUT_TICKS_DEF,
  parameter int SR_W = $clog2(SENSOR_TIMEOUT_TICKS + 1)
) (
  input  plc_pkg::plc_cfg_t   cfg,
  input  plc_pkg::plc_item_t  item,
  input  plc_pkg::plc_state_t st,
  input  logic [SR_W-1:0]     since_report,
  output plc_pkg::plc_state_t st_next,
  output logic [SR_W-1:0]     since_report_next,
  output plc_pkg::plc_result_t res
);

  localparam logic [SR_W-1:0] SR_LIMIT = SR_W'(SENSOR_TIMEOUT_TICKS);

  logic [plc_pkg::LEVEL_W-1:0] on_th;
  logic [plc_pkg::LEVEL_W-1:0] off_th;
  logic [plc_pkg::RUN_W-1:0]   limit;
  logic [plc_pkg::LEFT_W-1:0]  dur_sec;
  logic [plc_pkg::EVT_W-1:0]   evt;
  logic [plc_pkg::RUN_W-1:0]   tm_sec;

  // effective thresholds and run limit
  always_comb begin
    on_th  = (cfg.on_threshold != '0) ? cfg.on_threshold : plc_pkg::DEF_ON_TH;
    off_th = (cfg.off_threshold != '0) ? cfg.off_threshold : plc_pkg::DEF_OFF_TH;
    tm_sec = (plc_pkg::RUN_W'(cfg.timeout_minutes[6:0]) << 6)
           - (plc_pkg::RUN_W'(cfg.timeout_minutes[6:0]) << 2);
    if (cfg.timeout_minutes == '0) begin
      limit = plc_pkg::DEF_TIMEOUT_SEC;
    end else if (cfg.timeout_minutes > plc_pkg::MAX_TIMEOUT_MIN) begin
      limit = plc_pkg::MAX_TIMEOUT_SEC;
    end else begin
      limit = tm_sec;
    end
    // minutes times 60 as two shifts
    dur_sec = (plc_pkg::LEFT_W'(item.duration_min) << 6)
            - (plc_pkg::LEFT_W'(item.duration_min) << 2);
  end

  // next state for one word
  always_comb begin
    st_next           = st;
    since_report_next = since_report;
    evt               = plc_pkg::EVT_NONE;
    unique case (item.func)
      plc_pkg::FUNC_TICK: begin
        // time advances first
        if (since_report < SR_LIMIT) begin
          since_report_next = since_report + 1'b1;
        end
        if (st.running && st.run_seconds < plc_pkg::RUN_SAT) begin
          st_next.run_seconds = st.run_seconds + 1'b1;
        end
        if (st.override_left != '0) begin
          st_next.override_left = st.override_left - 1'b1;
        end
        // control decision
        if (st.override_on) begin
          if (st_next.override_left == '0) begin
            st_next.override_on = 1'b0;
            st_next.running     = 1'b0;
            evt = plc_pkg::EVT_MAN_EXPIRE;
          end else if (!st.running) begin
            st_next.running     = 1'b1;
            st_next.run_seconds = '0;
          end
        end else if (since_report_next >= SR_LIMIT) begin
          st_next.sensor_seen = 1'b0;
          if (st.running) begin
            st_next.override_left = '0;
            st_next.running       = 1'b0;
            evt = plc_pkg::EVT_OFF_SENSOR;
          end
        end else begin
          st_next.sensor_seen = 1'b1;
          if (st.running && st_next.run_seconds >= limit) begin
            st_next.override_left = '0;
            st_next.running       = 1'b0;
            evt = plc_pkg::EVT_OFF_TIMEOUT;
          end else if (st.last_level <= on_th && !st.running) begin
            st_next.running     = 1'b1;
            st_next.run_seconds = '0;
            evt = plc_pkg::EVT_ON_LOW;
          end else if (st.last_level >= off_th && st.running) begin
            st_next.override_left = '0;
            st_next.running       = 1'b0;
            evt = plc_pkg::EVT_OFF_HIGH;
          end
        end
        // counters after the decision
        if (st_next.running) begin
          st_next.total_run = st.total_run + 1'b1;
        end
        st_next.ticks_up = st.ticks_up + 1'b1;
      end
      plc_pkg::FUNC_REPORT: begin
        st_next.last_level = item.level_pct;
        since_report_next  = '0;
      end
      plc_pkg::FUNC_START: begin
        if (item.duration_min != '0) begin
          st_next.override_on   = 1'b1;
          st_next.override_left = dur_sec;
          st_next.running       = 1'b1;
          if (!st.running) begin
            st_next.run_seconds = '0;
          end
          evt = plc_pkg::EVT_MAN_START;
        end else begin
          st_next.override_on   = 1'b0;
          st_next.override_left = '0;
          st_next.running       = 1'b0;
          evt = plc_pkg::EVT_MAN_STOP;
        end
      end
      plc_pkg::FUNC_STOP: begin
        st_next.override_on   = 1'b0;
        st_next.override_left = '0;
        st_next.running       = 1'b0;
        evt = plc_pkg::EVT_MAN_STOP;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  // result word from the updated state
  always_comb begin
    res.pump_on              = st_next.running;
    res.sensor_present       = st_next.sensor_seen;
    res.manual_active        = st_next.override_on;
    res.override_secs_left   = st_next.override_on ? st_next.override_left : '0;
    res.pump_runtime_total   = st_next.total_run;
    res.uptime_sec           = st_next.ticks_up;
    res.level_now            = st_next.last_level;
    res.event_res            = evt;
  end

endmodule

`default_nettype wire

/* rtl/core/pump_level_controller_top.sv */
// pump level controller
// words go from the input word register to the result word register
// one word per cycle unless stalled; state loop closes in the single update stage
// reset (rst, synchronous): pump off, no override, all counters zero, the config
// registers zero, both pipeline stages empty
`default_nettype none

module pump_level_controller_top #(
  parameter int SENSOR_TIMEOUT_TICKS = plc_pkg::SENSOR_TIMEOUT_TICKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [plc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [plc_pkg::FUNC_W-1:0]        func,
  input  wire logic [plc_pkg::LEVEL_W-1:0]       level_pct,
  input  wire logic [plc_pkg::DUR_W-1:0]         duration_min,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   pump_on,
  output logic                                   sensor_present,
  output logic                                   manual_active,
  output logic [plc_pkg::LEFT_W-1:0]             override_secs_left,
  output logic [plc_pkg::CNT_W-1:0]              pump_runtime_total,
  output logic [plc_pkg::CNT_W-1:0]              uptime_sec,
  output logic [plc_pkg::LEVEL_W-1:0]            level_now,
  output logic [plc_pkg::EVT_W-1:0]              event_res
);

  localparam int SR_W = $clog2(SENSOR_TIMEOUT_TICKS + 1);

  plc_pkg::plc_cfg_t    cfg;
  plc_pkg::plc_item_t   item;
  logic                 item_valid;
  plc_pkg::plc_state_t  st;
  plc_pkg::plc_state_t  st_next;
  logic [SR_W-1:0]      since_report;
  logic [SR_W-1:0]      since_report_next;
  plc_pkg::plc_result_t res_next;
  plc_pkg::plc_result_t res;
  logic                 res_valid;
  logic                 advance;
  logic                 in_take;

  // handshake control
  assign advance  = !res_valid || !out_stall;
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plc_pkg::CFG_ON_TH:   cfg.on_threshold    <= cfg_data[plc_pkg::LEVEL_W-1:0];
        plc_pkg::CFG_OFF_TH:  cfg.off_threshold   <= cfg_data[plc_pkg::LEVEL_W-1:0];
        plc_pkg::CFG_TIMEOUT: cfg.timeout_minutes <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.func         <= func;
      item.level_pct    <= level_pct;
      item.duration_min <= duration_min;
    end
  end

  // state update and result computation
  plc_ctrl #(
    .SENSOR_TIMEOUT_TICKS (SENSOR_TIMEOUT_TICKS),
    .SR_W                 (SR_W)
  ) u_ctrl (
    .cfg               (cfg),
    .item              (item),
    .st                (st),
    .since_report      (since_report),
    .st_next           (st_next),
    .since_report_next (since_report_next),
    .res               (res_next)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      since_report <= '0;
    end else if (item_valid && advance) begin
      st           <= st_next;
      since_report <= since_report_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      res <= res_next;
    end
  end

  // output ports
  assign out_valid            = res_valid;
  assign pump_on              = res.pump_on;
  assign sensor_present       = res.sensor_present;
  assign manual_active        = res.manual_active;
  assign override_secs_left   = res.override_secs_left;
  assign pump_runtime_total   = res.pump_runtime_total;
  assign uptime_sec           = res.uptime_sec;
  assign level_now            = res.level_now;
  assign event_res            = res.event_res;

endmodule

`default_nettype wire

/* tb/pump_level_controller_top_tb.sv */
module pump_level_controller_top_tb;
  import plc_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SENSOR_TICKS    = SENSOR_TIMEOUT_TICKS_DEF;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_ON_TH;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     func         = FUNC_TICK;
  logic [LEVEL_W-1:0]    level_pct    = '0;
  logic [DUR_W-1:0]      duration_min = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  pump_on;
  logic                  sensor_present;
  logic                  manual_active;
  logic [LEFT_W-1:0]     override_secs_left;
  logic [CNT_W-1:0]      pump_runtime_total;
  logic [CNT_W-1:0]      uptime_sec;
  logic [LEVEL_W-1:0]    level_now;
  logic [EVT_W-1:0]      event_res;

  // idling percentages for both sides
  int gap_pct   = 0;
  int stall_pct = 0;

  int words_sent   = 0;
  int results_seen = 0;
  int failures     = 0;
  int idle_cycles  = 0;

  plc_result_t pending_status[$];

  // register copies used by the pump model
  logic [LEVEL_W-1:0] on_th_reg  = '0;
  logic [LEVEL_W-1:0] off_th_reg = '0;
  logic [DUR_W-1:0]   tmo_reg    = '0;

  // pump model state
  logic               pump_running = 1'b0;
  logic               manual_on    = 1'b0;
  logic [LEFT_W-1:0]  manual_left  = '0;
  logic [RUN_W-1:0]   run_secs     = '0;
  int                 quiet_ticks  = 0;
  logic               sensor_ok    = 1'b0;
  logic [LEVEL_W-1:0] level_seen   = '0;
  logic [CNT_W-1:0]   run_total    = '0;
  logic [CNT_W-1:0]   uptime       = '0;

  pump_level_controller_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .level_pct(level_pct),
    .duration_min(duration_min),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pump_on(pump_on),
    .sensor_present(sensor_present),
    .manual_active(manual_active),
    .override_secs_left(override_secs_left),
    .pump_runtime_total(pump_runtime_total),
    .uptime_sec(uptime_sec),
    .level_now(level_now),
    .event_res(event_res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // thresholds and run limit in force
  function automatic logic [LEVEL_W-1:0] active_on_th();
    return (on_th_reg != 0) ? on_th_reg : DEF_ON_TH;
  endfunction

  function automatic logic [LEVEL_W-1:0] active_off_th();
    return (off_th_reg != 0) ? off_th_reg : DEF_OFF_TH;
  endfunction

  function automatic int unsigned run_limit_sec();
    int unsigned lim;
    lim = (tmo_reg != 0) ? int'(tmo_reg) * 60 : int'(DEF_TIMEOUT_SEC);
    if (lim > int'(MAX_TIMEOUT_SEC)) lim = int'(MAX_TIMEOUT_SEC);
    return lim;
  endfunction

  function automatic void engage_pump();
    if (!pump_running) begin
      pump_running = 1'b1;
      run_secs = '0;
    end
  endfunction

  function automatic void halt_pump();
    manual_on = 1'b0;
    manual_left = '0;
    pump_running = 1'b0;
  endfunction

  // status word the controller reports after one input word
  function automatic plc_result_t next_pump_status(input logic [FUNC_W-1:0] f,
                                                   input logic [LEVEL_W-1:0] lv,
                                                   input logic [DUR_W-1:0] d);
    plc_result_t r;
    logic [EVT_W-1:0] ev;
    ev = EVT_NONE;
    case (f)
      FUNC_TICK: begin
        if (quiet_ticks < SENSOR_TICKS) quiet_ticks++;
        if (pump_running && run_secs < RUN_SAT) run_secs++;
        if (manual_left != 0) manual_left--;
        // manual override first, then sensor judgement, then automatic control
        if (manual_on) begin
          if (manual_left == 0) begin
            halt_pump();
            ev = EVT_MAN_EXPIRE;
          end else begin
            engage_pump();
          end
        end else if (quiet_ticks >= SENSOR_TICKS) begin
          sensor_ok = 1'b0;
          if (pump_running) begin
            halt_pump();
            ev = EVT_OFF_SENSOR;
          end
        end else begin
          sensor_ok = 1'b1;
          if (pump_running && run_secs >= run_limit_sec()) begin
            halt_pump();
            ev = EVT_OFF_TIMEOUT;
          end else if (level_seen <= active_on_th() && !pump_running) begin
            engage_pump();
            ev = EVT_ON_LOW;
          end else if (level_seen >= active_off_th() && pump_running) begin
            halt_pump();
            ev = EVT_OFF_HIGH;
          end
        end
        if (pump_running) run_total++;
        uptime++;
      end
      FUNC_REPORT: begin
        level_seen = lv;
        quiet_ticks = 0;
      end
      default: begin
        // a start of zero minutes behaves as a stop
        if (f == FUNC_START && d != 0) begin
          manual_on = 1'b1;
          manual_left = LEFT_W'(32'(d) * 32'd60);
          engage_pump();
          ev = EVT_MAN_START;
        end else begin
          halt_pump();
          ev = EVT_MAN_STOP;
        end
      end
    endcase
    r.pump_on = pump_running;
    r.sensor_present = sensor_ok;
    r.manual_active = manual_on;
    r.override_secs_left = manual_on ? manual_left : '0;
    r.pump_runtime_total = run_total;
    r.uptime_sec = uptime;
    r.level_now = level_seen;
    r.event_res = ev;
    return r;
  endfunction

  // watch both channels: check result words, queue predictions for input words
  always @(posedge clk) begin : status_monitor
    plc_result_t got;
    plc_result_t want;
    logic busy;
    busy = cfg_we;
    if (!rst && out_valid && !out_stall) begin
      busy = 1'b1;
      results_seen++;
      got = {pump_on, sensor_present, manual_active, override_secs_left,
             pump_runtime_total, uptime_sec, level_now, event_res};
      if (pending_status.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result word %0d arrived with nothing pending", results_seen);
      end else begin
        want = pending_status.pop_front();
        if (got.pump_on !== want.pump_on || got.sensor_present !== want.sensor_present ||
            got.manual_active !== want.manual_active ||
            got.override_secs_left !== want.override_secs_left ||
            got.pump_runtime_total !== want.pump_runtime_total ||
            got.uptime_sec !== want.uptime_sec || got.level_now !== want.level_now ||
            got.event_res !== want.event_res) begin
          failures++;
          if (failures <= 10) begin
            $display("result word %0d: exp pump=%0d sens=%0d man=%0d left=%0d run=%0d up=%0d lvl=%0d evt=%0d",
                     results_seen, want.pump_on, want.sensor_present, want.manual_active,
                     want.override_secs_left, want.pump_runtime_total, want.uptime_sec,
                     want.level_now, want.event_res);
            $display("                 got pump=%0d sens=%0d man=%0d left=%0d run=%0d up=%0d lvl=%0d evt=%0d",
                     got.pump_on, got.sensor_present, got.manual_active,
                     got.override_secs_left, got.pump_runtime_total, got.uptime_sec,
                     got.level_now, got.event_res);
          end
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      busy = 1'b1;
      pending_status.push_back(next_pump_status(func, level_pct, duration_min));
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
  end

  // watchdog on cycles without any transfer
  initial begin
    while (idle_cycles < WATCHDOG_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // present one word and hold it until accepted
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [LEVEL_W-1:0] lv,
                           input logic [DUR_W-1:0] d);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    level_pct <= lv;
    duration_min <= d;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // stop sending and wait for every pending status word
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write all three registers while the block is idle
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] on_v,
                                input logic [CFG_DATA_W-1:0] off_v,
                                input logic [CFG_DATA_W-1:0] tmo_v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ON_TH;
    cfg_data <= on_v;
    @(posedge clk);
    cfg_index <= CFG_OFF_TH;
    cfg_data <= off_v;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= tmo_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    on_th_reg = on_v[LEVEL_W-1:0];
    off_th_reg = off_v[LEVEL_W-1:0];
    tmo_reg = tmo_v;
  endtask

  // level biased toward the thresholds and the range ends
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return active_on_th() + LEVEL_W'($urandom_range(0, 2)) - 8'd1;
      1: return active_off_th() + LEVEL_W'($urandom_range(0, 2)) - 8'd1;
      2: return 8'd0;
      3: return 8'd255;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // defaults after reset: hysteresis edges, manual start and stop corners
  task automatic test_power_on_defaults();
    send_word(FUNC_TICK, 8'd0, 16'd0);
    send_word(FUNC_REPORT, 8'd255, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    send_word(FUNC_REPORT, 8'd20, 16'hFFFF);
    send_word(FUNC_TICK, 8'hFF, 16'hFFFF);
    send_word(FUNC_REPORT, 8'd80, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    send_word(FUNC_REPORT, 8'd79, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    // zero minutes counts as a stop
    send_word(FUNC_START, 8'd0, 16'd0);
    send_word(FUNC_START, 8'hFF, 16'hFFFF);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    // restart while already running reloads the countdown
    send_word(FUNC_START, 8'd0, 16'd1);
    send_word(FUNC_REPORT, 8'd255, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    send_word(FUNC_STOP, 8'hFF, 16'hFFFF);
    send_word(FUNC_STOP, 8'd0, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
  endtask

  // threshold and timeout registers at their extremes
  task automatic test_register_extremes();
    apply_settings(16'h00FF, 16'h00FF, 16'hFFFF);
    send_word(FUNC_REPORT, 8'd255, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    apply_settings(16'd1, 16'd1, 16'd1);
    send_word(FUNC_REPORT, 8'd0, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
    send_word(FUNC_REPORT, 8'd1, 16'd0);
    send_word(FUNC_TICK, 8'd0, 16'd0);
  endtask

  // random mix of automatic runs, manual runs, timeouts, sensor loss and noise
  task automatic test_random_traffic(input int words, input logic [CFG_DATA_W-1:0] on_v,
                                     input logic [CFG_DATA_W-1:0] off_v,
                                     input logic [CFG_DATA_W-1:0] tmo_v);
    int first;
    int sel;
    int n;
    int span;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    apply_settings(on_v, off_v, tmo_v);
    first = words_sent;
    while (words_sent - first < words) begin
      // now and then let everything drain before going on
      if ($urandom_range(0, 99) < 3) drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        // automatic control with sparse reports
        n = $urandom_range(1, 40);
        repeat (n) begin
          if ($urandom_range(0, 99) < 8)
            send_word(FUNC_REPORT, pick_level(), DUR_W'($urandom));
          else
            send_word(FUNC_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
        end
      end else if (sel < 55) begin
        // manual run, mostly short enough to expire
        if ($urandom_range(0, 99) < 80)
          send_word(FUNC_START, LEVEL_W'($urandom), DUR_W'($urandom_range(1, 2)));
        else
          send_word(FUNC_START, LEVEL_W'($urandom), DUR_W'($urandom));
        n = $urandom_range(1, 130);
        repeat (n) begin
          if ($urandom_range(0, 99) < 5)
            send_word(FUNC_REPORT, pick_level(), DUR_W'($urandom));
          else
            send_word(FUNC_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
        end
        if ($urandom_range(0, 99) < 30)
          send_word(FUNC_STOP, LEVEL_W'($urandom), DUR_W'($urandom));
      end else if (sel < 65) begin
        // low level, then keep the sensor alive at a mid level until the run limit where it is short
        lo = active_on_th();
        hi = active_off_th();
        send_word(FUNC_REPORT, LEVEL_W'($urandom_range(0, lo)), DUR_W'($urandom));
        n = (run_limit_sec() > 150) ? 155 : int'(run_limit_sec()) + 5;
        for (int i = 0; i < n; i++) begin
          if (i % 20 == 19) begin
            if (hi > lo + 1) begin
              span = int'(hi) - int'(lo) - 1;
              send_word(FUNC_REPORT, lo + LEVEL_W'($urandom_range(1, span)), 16'd0);
            end else begin
              send_word(FUNC_REPORT, lo, 16'd0);
            end
          end else begin
            send_word(FUNC_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
          end
        end
      end else if (sel < 75) begin
        // silent sensor
        n = $urandom_range(SENSOR_TICKS, SENSOR_TICKS + 6);
        repeat (n) send_word(FUNC_TICK, LEVEL_W'($urandom), DUR_W'($urandom));
      end else begin
        // unstructured words
        n = $urandom_range(1, 6);
        repeat (n)
          send_word(FUNC_W'($urandom_range(0, 3)), LEVEL_W'($urandom), DUR_W'($urandom));
      end
    end
  endtask

  initial begin
    gap_pct = 10;
    stall_pct = 79;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on_defaults();
    test_register_extremes();
    test_random_traffic(270, 16'd0, 16'd0, 16'd1);
    test_random_traffic(270, 16'd40, 16'd60, 16'd2);
    gap_pct = 79;
    stall_pct = 10;
    test_random_traffic(270, 16'h00FF, {8'($urandom), 8'd1}, 16'hFFFF);
    test_random_traffic(270, 16'd1, 16'd255, 16'd1);
    gap_pct = 0;
    stall_pct = 0;
    test_random_traffic(270, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                        CFG_DATA_W'($urandom_range(0, 3)));
    test_random_traffic(270, 16'd0, 16'd0, 16'd0);
    drain_results();
    repeat (8) @(posedge clk);
    if (failures == 0 && pending_status.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* pump_level_controller_top.f */
rtl/core/plc_pkg.sv
rtl/core/plc_ctrl.sv
rtl/core/pump_level_controller_top.sv
tb/pump_level_controller_top_tb.sv
